### rtl/sloe_pkg.sv
// shared types and constants for the stack list operations engine
// no dependencies; used by sloe_seq and stack_list_operations_engine

package sloe_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned OP_W  = 3;

  // request codes carried in the input tuser; codes 5 to 7 are no-ops
  typedef enum logic [OP_W-1:0] {
    OP_SEARCH = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_SWAP   = 3'd3,
    OP_DOUBLE = 3'd4
  } op_e;

  // sequencer status toward the stream front end
  typedef struct packed {
    logic idle;
    logic res_valid;
    logic found;
    logic changed;
  } stat_t;

endpackage

### rtl/sloe_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module sloe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/sloe_seq.sv
// operation sequencer: walks the key ram one entry per cycle, read-modify-write
// depends on sloe_pkg; drives one sloe_ram instance through its ports

module sloe_seq #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned CW = $clog2(DEPTH + 1),
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_valid_i,
  input  sloe_pkg::op_e              op_i,
  input  logic [sloe_pkg::KEY_W-1:0] key_i,
  input  logic [CW-1:0]              pos_a_i,
  input  logic [CW-1:0]              pos_b_i,
  input  logic                       res_ready_i,
  output sloe_pkg::stat_t            stat_o,
  output logic [CW-1:0]              count_o,
  output logic                       ram_re_o,
  output logic [AW-1:0]              ram_raddr_o,
  output logic                       ram_we_o,
  output logic [AW-1:0]              ram_waddr_o,
  output logic [sloe_pkg::KEY_W-1:0] ram_wdata_o,
  input  logic [sloe_pkg::KEY_W-1:0] ram_rdata_i
);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_SCAN = 9'b000000010,
    ST_SHDN = 9'b000000100,
    ST_SHUP = 9'b000001000,
    ST_SWPA = 9'b000010000,
    ST_SWPB = 9'b000100000,
    ST_SWPC = 9'b001000000,
    ST_SWPD = 9'b010000000,
    ST_DBL  = 9'b100000000
  } state_e;

  localparam logic [CW-1:0] Full = CW'(DEPTH);

  // done is not a separate state: a flag in the idle state holds the result
  logic done_q, done_d;

  state_e                     state_q, state_d;
  logic [CW-1:0]              cnt_q, cnt_d;
  logic                       rvld_q, rvld_d;
  sloe_pkg::op_e              op_q, op_d;
  logic [sloe_pkg::KEY_W-1:0] key_q, key_d;
  logic [sloe_pkg::KEY_W-1:0] tmp_q, tmp_d;
  logic [CW-1:0]              rp_q, rp_d;
  logic [CW-1:0]              idx_q, idx_d;
  logic [AW-1:0]              ra_q, ra_d;
  logic [AW-1:0]              addr_a_q, addr_a_d;
  logic [AW-1:0]              addr_b_q, addr_b_d;
  logic                       found_q, found_d;
  logic                       changed_q, changed_d;

  logic [CW-1:0] rp_m1;
  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] diff_a;
  logic [CW-1:0] diff_b;
  logic          hit;
  logic          swap_ok;

  assign rp_m1  = rp_q - 1'b1;
  assign cnt_m1 = cnt_q - 1'b1;
  assign diff_a = cnt_q - pos_a_i;
  assign diff_b = cnt_q - pos_b_i;
  assign hit    = rvld_q && (ram_rdata_i == key_q);
  assign swap_ok = (pos_a_i != pos_b_i) && (pos_a_i != '0) && (pos_b_i != '0) &&
                   (pos_a_i <= cnt_q) && (pos_b_i <= cnt_q);

  always_comb begin
    state_d     = state_q;
    done_d      = done_q;
    cnt_d       = cnt_q;
    op_d        = op_q;
    key_d       = key_q;
    tmp_d       = tmp_q;
    rp_d        = rp_q;
    idx_d       = idx_q;
    ra_d        = ra_q;
    addr_a_d    = addr_a_q;
    addr_b_d    = addr_b_q;
    found_d     = found_q;
    changed_d   = changed_q;
    rvld_d      = 1'b0;
    ram_re_o    = 1'b0;
    ram_raddr_o = rp_q[AW-1:0];
    ram_we_o    = 1'b0;
    ram_waddr_o = ra_q;
    ram_wdata_o = ram_rdata_i;

    unique case (state_q)
      ST_IDLE: begin
        if (done_q) begin
          // result waits for the output register
          if (res_ready_i) begin
            done_d = 1'b0;
          end
        end else if (req_valid_i) begin
          op_d      = op_i;
          key_d     = key_i;
          found_d   = 1'b0;
          changed_d = 1'b0;
          rp_d      = '0;
          done_d    = 1'b1;
          unique case (op_i)
            sloe_pkg::OP_SEARCH, sloe_pkg::OP_DELETE: begin
              if (cnt_q != '0) begin
                state_d = ST_SCAN;
                done_d  = 1'b0;
              end
            end
            sloe_pkg::OP_INSERT: begin
              if ((pos_a_i != '0) && (cnt_q != Full)) begin
                rp_d    = cnt_q;
                idx_d   = (pos_a_i > cnt_q) ? '0 : CW'(cnt_q - pos_a_i + 1'b1);
                state_d = ST_SHUP;
                done_d  = 1'b0;
              end
            end
            sloe_pkg::OP_SWAP: begin
              if (swap_ok) begin
                addr_a_d = diff_a[AW-1:0];
                addr_b_d = diff_b[AW-1:0];
                state_d  = ST_SWPA;
                done_d   = 1'b0;
              end
            end
            sloe_pkg::OP_DOUBLE: begin
              if (cnt_q != '0) begin
                state_d = ST_DBL;
                done_d  = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        ram_re_o = (rp_q < cnt_q) && !hit;
        rvld_d   = ram_re_o;
        ra_d     = rp_q[AW-1:0];
        if (ram_re_o) begin
          rp_d = rp_q + 1'b1;
        end
        if (hit) begin
          if (op_q == sloe_pkg::OP_DELETE) begin
            rp_d    = CW'(ra_q) + 1'b1;
            state_d = ST_SHDN;
          end else begin
            found_d = 1'b1;
            state_d = ST_IDLE;
            done_d  = 1'b1;
          end
        end else if (rvld_q && (CW'(ra_q) == cnt_m1)) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
        end
      end
      ST_SHDN: begin
        // entries above the match move down by one
        ram_re_o = rp_q < cnt_q;
        rvld_d   = ram_re_o;
        ra_d     = rp_q[AW-1:0];
        if (ram_re_o) begin
          rp_d = rp_q + 1'b1;
        end
        if (rvld_q) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = ra_q - 1'b1;
        end else if (!ram_re_o) begin
          cnt_d     = cnt_m1;
          found_d   = 1'b1;
          changed_d = 1'b1;
          state_d   = ST_IDLE;
          done_d    = 1'b1;
        end
      end
      ST_SHUP: begin
        // entries from the insert point up move up by one, top first
        ram_re_o    = rp_q > idx_q;
        ram_raddr_o = rp_m1[AW-1:0];
        rvld_d      = ram_re_o;
        ra_d        = rp_m1[AW-1:0];
        if (ram_re_o) begin
          rp_d = rp_m1;
        end
        if (rvld_q) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = ra_q + 1'b1;
        end else if (!ram_re_o) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = idx_q[AW-1:0];
          ram_wdata_o = key_q;
          cnt_d       = cnt_q + 1'b1;
          changed_d   = 1'b1;
          state_d     = ST_IDLE;
          done_d      = 1'b1;
        end
      end
      ST_SWPA: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = addr_a_q;
        state_d     = ST_SWPB;
      end
      ST_SWPB: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = addr_b_q;
        tmp_d       = ram_rdata_i;
        state_d     = ST_SWPC;
      end
      ST_SWPC: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = addr_a_q;
        state_d     = ST_SWPD;
      end
      ST_SWPD: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = addr_b_q;
        ram_wdata_o = tmp_q;
        changed_d   = 1'b1;
        state_d     = ST_IDLE;
        done_d      = 1'b1;
      end
      ST_DBL: begin
        ram_re_o = rp_q < cnt_q;
        rvld_d   = ram_re_o;
        ra_d     = rp_q[AW-1:0];
        if (ram_re_o) begin
          rp_d = rp_q + 1'b1;
        end
        if (rvld_q) begin
          ram_we_o    = 1'b1;
          ram_wdata_o = {ram_rdata_i[sloe_pkg::KEY_W-2:0], 1'b0};
        end else if (!ram_re_o) begin
          changed_d = 1'b1;
          state_d   = ST_IDLE;
          done_d    = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      rvld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
      rvld_q  <= rvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    key_q     <= key_d;
    tmp_q     <= tmp_d;
    rp_q      <= rp_d;
    idx_q     <= idx_d;
    ra_q      <= ra_d;
    addr_a_q  <= addr_a_d;
    addr_b_q  <= addr_b_d;
    found_q   <= found_d;
    changed_q <= changed_d;
  end

  assign stat_o.idle      = (state_q == ST_IDLE) && !done_q;
  assign stat_o.res_valid = (state_q == ST_IDLE) && done_q;
  assign stat_o.found     = found_q;
  assign stat_o.changed   = changed_q;
  assign count_o          = cnt_q;

endmodule

### rtl/stack_list_operations_engine.sv
// top level of the stack list operations engine: stream ports, result register
// depends on sloe_pkg, sloe_seq and sloe_ram

// A bounded stack of up to DEPTH signed 32-bit keys kept in one synchronous
// ram (index 0 is the bottom, position 1 is the top) and served one request
// at a time. The request code travels in s_axis_tuser, the key and the two
// positions in s_axis_tdata; every request yields exactly one result
// transaction with found, changed and the element count after the request.
// The sequencer walks the single ram read port one entry a cycle (scan,
// shift or doubling pass). A new request is taken once the previous result
// has moved into the output register, so a stalled m_axis side costs at
// most one result of slack. No clearing pass is needed after reset: only
// entries below the count are ever read.

module stack_list_operations_engine #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned CW    = $clog2(DEPTH + 1),
  localparam int unsigned AW    = $clog2(DEPTH),
  localparam int unsigned IN_W  = ((sloe_pkg::KEY_W + 2 * CW + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((2 + CW + 7) / 8) * 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // key, position_a, position_b, zero pad
  input  logic [IN_W-1:0]           s_axis_tdata,
  // op
  input  logic [sloe_pkg::OP_W-1:0] s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // found, changed, element_count, zero pad
  output logic [OUT_W-1:0]          m_axis_tdata
);

  sloe_pkg::stat_t            stat;
  logic [CW-1:0]              seq_count;
  logic                       res_ready;
  logic                       res_load;

  // ram port between sequencer and storage
  logic                       ram_re;
  logic [AW-1:0]              ram_raddr;
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [sloe_pkg::KEY_W-1:0] ram_wdata;
  logic [sloe_pkg::KEY_W-1:0] ram_rdata;

  // result register, parts the sequencer from the master side
  logic          m_valid_q, m_valid_d;
  logic          m_found_q;
  logic          m_changed_q;
  logic [CW-1:0] m_count_q;

  assign s_axis_tready = stat.idle;

  sloe_seq #(
    .DEPTH(DEPTH)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(s_axis_tvalid),
    .op_i       (sloe_pkg::op_e'(s_axis_tuser)),
    .key_i      (s_axis_tdata[sloe_pkg::KEY_W-1:0]),
    .pos_a_i    (s_axis_tdata[sloe_pkg::KEY_W +: CW]),
    .pos_b_i    (s_axis_tdata[sloe_pkg::KEY_W + CW +: CW]),
    .res_ready_i(res_ready),
    .stat_o     (stat),
    .count_o    (seq_count),
    .ram_re_o   (ram_re),
    .ram_raddr_o(ram_raddr),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_rdata_i(ram_rdata)
  );

  sloe_ram #(
    .WIDTH(sloe_pkg::KEY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // the register takes a new result when empty or being drained this cycle
  assign res_ready = !m_valid_q || m_axis_tready;
  assign res_load  = stat.res_valid && res_ready;

  always_comb begin
    m_valid_d = m_valid_q;
    if (res_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      m_found_q   <= stat.found;
      m_changed_q <= stat.changed;
      m_count_q   <= seq_count;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_W'({m_count_q, m_changed_q, m_found_q});

  // shift and doubling passes never read the entry written in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("ram read and write collide on one entry");

  // one transaction at a time: the slave side closes right after a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while sequencer busy");

  // the reported count never runs past the capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_count_q <= CW'(DEPTH)))
    else $error("element count exceeds depth");

endmodule

### tb/sloe_stack_checker.sv
// scoreboard for the stack list operations engine: keeps its own copy of the stack,
// predicts one result per accepted request and compares it with the result stream
// depends on sloe_pkg for the request codes and key width
`timescale 1ns / 100ps

module sloe_stack_checker #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned CW    = $clog2(DEPTH + 1),
  localparam int unsigned IN_W  = ((sloe_pkg::KEY_W + 2 * CW + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((2 + CW + 7) / 8) * 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_tvalid_i,
  input  logic                      s_tready_i,
  input  logic [IN_W-1:0]           s_tdata_i,
  input  logic [sloe_pkg::OP_W-1:0] s_tuser_i,
  input  logic                      m_tvalid_i,
  input  logic                      m_tready_i,
  input  logic [OUT_W-1:0]          m_tdata_i,
  output int                        fail_count_o,
  output int                        pending_o
);

  // same layout as the result tdata: found in bit 0, then changed, then count
  typedef struct packed {
    logic [CW-1:0] count;
    logic          changed;
    logic          found;
  } stack_result_t;

  // index 0 is the bottom, position 1 is entry fill - 1
  logic [sloe_pkg::KEY_W-1:0] stack_keys [DEPTH];
  int unsigned                stack_fill;
  stack_result_t              expected_results [$];
  int                         fails;
  int                         pending;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  task automatic apply_request(input logic [sloe_pkg::OP_W-1:0] op,
                               input logic [sloe_pkg::KEY_W-1:0] key,
                               input logic [CW-1:0] pos_a, input logic [CW-1:0] pos_b,
                               output stack_result_t res);
    int unsigned                n;
    int unsigned                idx;
    int unsigned                slot;
    int unsigned                ia;
    int unsigned                ib;
    logic [sloe_pkg::KEY_W-1:0] tmp;
    logic                       hit;
    n   = stack_fill;
    idx = 0;
    hit = 1'b0;
    res = '0;
    // first match counted from the bottom
    for (int unsigned i = 0; i < n; i++) begin
      if (!hit && stack_keys[i] == key) begin
        hit = 1'b1;
        idx = i;
      end
    end
    case (op)
      sloe_pkg::OP_SEARCH: res.found = hit;
      sloe_pkg::OP_INSERT: begin
        if (pos_a >= 1 && n < DEPTH) begin
          slot = (pos_a > n + 1) ? n + 1 : pos_a;
          idx  = n + 1 - slot;
          for (int unsigned i = n; i > idx; i--) stack_keys[i] = stack_keys[i-1];
          stack_keys[idx] = key;
          n++;
          res.changed = 1'b1;
        end
      end
      sloe_pkg::OP_DELETE: begin
        if (hit) begin
          for (int unsigned i = idx; i + 1 < n; i++) stack_keys[i] = stack_keys[i+1];
          n--;
          res.found   = 1'b1;
          res.changed = 1'b1;
        end
      end
      sloe_pkg::OP_SWAP: begin
        if (pos_a != pos_b && pos_a >= 1 && pos_a <= n && pos_b >= 1 && pos_b <= n) begin
          ia = n - pos_a;
          ib = n - pos_b;
          tmp            = stack_keys[ia];
          stack_keys[ia] = stack_keys[ib];
          stack_keys[ib] = tmp;
          res.changed    = 1'b1;
        end
      end
      sloe_pkg::OP_DOUBLE: begin
        for (int unsigned i = 0; i < n; i++) stack_keys[i] = stack_keys[i] << 1;
        res.changed = (n > 0);
      end
      default: ;
    endcase
    stack_fill = n;
    res.count  = n[CW-1:0];
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    stack_result_t want;
    stack_result_t got;
    if (!rst_ni) begin
      stack_fill = 0;
      expected_results.delete();
      fails   = 0;
      pending = 0;
    end else begin
      // results first: a request never answers in the cycle it is taken
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i[2+CW-1:0];
        if (expected_results.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: result transaction with no request outstanding (data %h)",
                     $realtime, m_tdata_i);
        end else begin
          want = expected_results.pop_front();
          if (got.found !== want.found || got.changed !== want.changed ||
              got.count !== want.count) begin
            fails++;
            if (fails <= 10)
              $display("%0t: mismatch found/changed/count: expected %0b/%0b/%0d got %0b/%0b/%0d",
                       $realtime, want.found, want.changed, want.count,
                       got.found, got.changed, got.count);
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        apply_request(s_tuser_i, s_tdata_i[sloe_pkg::KEY_W-1:0],
                      s_tdata_i[sloe_pkg::KEY_W +: CW],
                      s_tdata_i[sloe_pkg::KEY_W+CW +: CW], want);
        expected_results.push_back(want);
      end
      pending = expected_results.size();
    end
  end

endmodule

### tb/tb.sv
// top of the stack list operations engine testbench: clock, reset, request stimulus
// and result-side back-pressure; depends on sloe_pkg, sloe_stack_checker and the block
`timescale 1ns / 100ps

module tb;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned KW    = sloe_pkg::KEY_W;
  localparam int unsigned OW    = sloe_pkg::OP_W;
  localparam int unsigned IN_W  = ((KW + 2 * CW + 7) / 8) * 8;
  localparam int unsigned OUT_W = ((2 + CW + 7) / 8) * 8;

  // request codes the block treats as no-ops
  localparam logic [OW-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OW-1:0] OP_SPARE_HI = 3'd7;

  localparam int unsigned RANDOM_ITEMS = 160;   // per idling phase
  localparam int unsigned BURST_ITEMS  = 48;    // fill / drain bias period
  localparam int unsigned HOLD_CYCLES  = 400;   // long result-side hold-off
  localparam int unsigned TAIL_CYCLES  = 2 * DEPTH + 16;

  logic             clk   = 1'b0;
  logic             rst_n = 1'b0;

  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata  = '0;
  logic [OW-1:0]    s_axis_tuser  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  int               fail_count;
  int               pending;

  // receiver controls, written with nonblocking assignments by the stimulus
  int               stall_pct = 0;
  int               hold_req  = 0;
  // owned by the receiver process
  int               hold_seen = 0;
  int               hold_left = 0;

  // sender controls, owned by the stimulus process
  int               send_pct  = 0;
  logic [KW-1:0]    key_pool [8];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  stack_list_operations_engine #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  sloe_stack_checker #(
    .DEPTH(DEPTH)
  ) checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // result side: random stalls, plus a long hold-off whenever the stimulus asks
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // offer one request transaction, with random idle cycles ahead of it, and
  // return at the edge where it is taken; tvalid stays high into the next one
  task automatic push_request(input logic [OW-1:0] op, input logic [KW-1:0] key,
                              input logic [CW-1:0] pos_a, input logic [CW-1:0] pos_b);
    logic [IN_W-1:0] word;
    word = '0;
    word[KW-1:0]        = key;
    word[KW +: CW]      = pos_a;
    word[KW+CW +: CW]   = pos_b;
    while ($urandom_range(99) < send_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // sender pauses until every outstanding result has been taken
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // extremes plus random keys; most random requests draw from this pool so that
  // searches and deletes hit often
  task automatic refresh_key_pool();
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < 8; i++) key_pool[i] = $urandom;
  endtask

  // one random request; fill_bias leans toward inserts so the stack reaches full,
  // otherwise toward deletes so it empties again
  task automatic pick_request(input logic fill_bias, output logic [OW-1:0] op,
                              output logic [KW-1:0] key, output logic [CW-1:0] pos_a,
                              output logic [CW-1:0] pos_b);
    int unsigned r;
    int unsigned ins_w;
    int unsigned del_w;
    r     = $urandom_range(99);
    ins_w = fill_bias ? 62 : 15;
    del_w = fill_bias ? 8 : 45;
    key   = ($urandom_range(99) < 85) ? key_pool[$urandom_range(7)] : $urandom;
    pos_a = ($urandom_range(99) < 75) ? CW'($urandom_range(1, 8)) : CW'($urandom_range(0, 17));
    pos_b = ($urandom_range(99) < 75) ? CW'($urandom_range(1, 8)) : CW'($urandom_range(0, 17));
    if (r < ins_w)                       op = sloe_pkg::OP_INSERT;
    else if (r < ins_w + del_w)          op = sloe_pkg::OP_DELETE;
    else if (r < ins_w + del_w + 14)     op = sloe_pkg::OP_SEARCH;
    else if (r < ins_w + del_w + 26)     op = sloe_pkg::OP_SWAP;
    else if (r < ins_w + del_w + 30)     op = sloe_pkg::OP_DOUBLE;
    else                                 op = OW'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
  endtask

  initial begin
    logic [OW-1:0] op;
    logic [KW-1:0] key;
    logic [CW-1:0] pos_a;
    logic [CW-1:0] pos_b;
    logic [KW-1:0] fill_keys [4];

    fill_keys[0] = 32'h8000_0000;
    fill_keys[1] = 32'h7fff_ffff;
    fill_keys[2] = 32'h0000_0000;
    fill_keys[3] = 32'hffff_ffff;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, no idling on either side
    send_pct = 0;
    // empty stack: search and delete miss, doubling changes nothing
    push_request(sloe_pkg::OP_SEARCH, 32'h0000_0000, 5'd0, 5'd0);
    push_request(sloe_pkg::OP_DELETE, 32'h0000_0000, 5'd0, 5'd0);
    push_request(sloe_pkg::OP_DOUBLE, 32'h0000_0000, 5'd0, 5'd0);
    // insert at position zero is refused
    push_request(sloe_pkg::OP_INSERT, 32'h1234_5678, 5'd0, 5'd0);
    // fill to capacity at top, past-the-bottom and interior positions
    for (int i = 0; i < DEPTH; i++) begin
      case (i % 4)
        0:       pos_a = 5'd1;
        1:       pos_a = 5'd17;
        2:       pos_a = 5'd2;
        default: pos_a = 5'(i);
      endcase
      key = (i < 4) ? fill_keys[i] : {$urandom} ^ (32'h1 << i);
      push_request(sloe_pkg::OP_INSERT, key, pos_a, 5'd0);
    end
    // full stack refuses insert
    push_request(sloe_pkg::OP_INSERT, 32'h5555_aaaa, 5'd1, 5'd0);
    // swap top with bottom, equal positions, and a position past the count
    push_request(sloe_pkg::OP_SWAP, 32'h0, 5'd1, 5'd16);
    push_request(sloe_pkg::OP_SWAP, 32'h0, 5'd3, 5'd3);
    push_request(sloe_pkg::OP_SWAP, 32'h0, 5'd1, 5'd17);
    push_request(sloe_pkg::OP_SEARCH, 32'h7fff_ffff, 5'd0, 5'd0);
    push_request(sloe_pkg::OP_DELETE, 32'hffff_ffff, 5'd0, 5'd0);
    push_request(sloe_pkg::OP_DELETE, 32'h0bad_f00d, 5'd0, 5'd0);
    // doubling wraps the most negative key to zero
    push_request(sloe_pkg::OP_DOUBLE, 32'h0, 5'd0, 5'd0);
    push_request(OP_SPARE_HI, 32'hffff_ffff, 5'd31, 5'd31);
    wait_drained();

    // random part: four idling phases
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_pct = 0;  stall_pct <= 0;  end
        1:       begin send_pct = 63; stall_pct <= 0;  end
        2:       begin send_pct = 0;  stall_pct <= 63; end
        default: begin send_pct = 38; stall_pct <= 38; end
      endcase
      refresh_key_pool();
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
        pick_request(((i / BURST_ITEMS) % 2) == 0, op, key, pos_a, pos_b);
        push_request(op, key, pos_a, pos_b);
        // long result hold-off while requests keep coming, so the input stalls
        if (phase == 0 && i == 40) hold_req <= hold_req + 1;
        // mid-phase pause until every result is back
        if (i == RANDOM_ITEMS / 2) wait_drained();
      end
      wait_drained();
    end

    stall_pct <= 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### stack_list_operations_engine.f
rtl/sloe_pkg.sv
rtl/sloe_ram.sv
rtl/sloe_seq.sv
rtl/stack_list_operations_engine.sv
tb/sloe_stack_checker.sv
tb/tb.sv
